@@ rtl/core/running_window_min_max_defines.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the running window min/max block
// Shared property shapes, clocked on clk and disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef RUNNING_WINDOW_MIN_MAX_DEFINES_SVH
`define RUNNING_WINDOW_MIN_MAX_DEFINES_SVH

// Same-cycle implication
`define RWMM_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rwmm assertion failed");

// Next-cycle implication
`define RWMM_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rwmm assertion failed");

`endif

@@ rtl/core/rwmm_pkg.sv @@
// ---------------------------------------------------------------------------
// rwmm_pkg
// Constants, types and compare helpers for the running window min/max block.
// ---------------------------------------------------------------------------
package rwmm_pkg;

    localparam int WINDOW_MAX   = 64;
    localparam int SAMPLE_WIDTH = 32;
    localparam int LEN_W        = $clog2(WINDOW_MAX + 1);
    localparam int WIN_IN_W     = 7;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_SELECT_MAX   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_MODE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FIXED_WINDOW = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SKIP_MISSING = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PAD_START    = 3'd4;

    localparam logic [1:0] MODE_CUMULATIVE = 2'd0;
    localparam logic [1:0] MODE_FIXED      = 2'd1;
    localparam logic [1:0] MODE_PER_ITEM   = 2'd2;

    localparam logic [LEN_W-1:0] WIN_MAX_L = LEN_W'(WINDOW_MAX);

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] value;
        logic                           valid;
    } sample_t;

    typedef struct packed {
        logic [LEN_W-1:0]               remaining;
        logic signed [SAMPLE_WIDTH-1:0] best;
        logic                           best_valid;
    } token_t;

    // a strictly better than b under the selector
    function automatic logic rwmm_better(
        input logic signed [SAMPLE_WIDTH-1:0] a,
        input logic signed [SAMPLE_WIDTH-1:0] b,
        input logic                           sel_max
    );
        logic res;
        if (sel_max)
        begin
            res = (a > b);
        end
        else
        begin
            res = (a < b);
        end
        return res;
    endfunction

    // clip a window length to 1..WINDOW_MAX
    function automatic logic [LEN_W-1:0] rwmm_clip(input logic [WIN_IN_W-1:0] len);
        logic [LEN_W-1:0] res;
        if (len == '0)
        begin
            res = LEN_W'(1);
        end
        else if (LEN_W'(len) > WIN_MAX_L)
        begin
            res = WIN_MAX_L;
        end
        else
        begin
            res = LEN_W'(len);
        end
        return res;
    endfunction

endpackage

@@ rtl/core/running_window_min_max.sv @@
// ---------------------------------------------------------------------------
// running_window_min_max
// Cumulative mode (0 or 3) puts the result in the output register in the cycle
//   after the input transfer, sustaining one item per cycle while the output is not stalled.
// Windowed modes run one scan per item: the scan token walks the 64-cell history
//   row one cell per cycle; input stalls meanwhile.
// Reset clears control state and restores register defaults; no clearing pass.
// ---------------------------------------------------------------------------
module running_window_min_max (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // input channel
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [rwmm_pkg::SAMPLE_WIDTH-1:0] sample_value,
    input  logic                                  sample_missing,
    input  logic [rwmm_pkg::WIN_IN_W-1:0]         window_len,
    input  logic                                  series_start,
    // output channel
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [rwmm_pkg::SAMPLE_WIDTH-1:0] extreme_value,
    output logic                                  extreme_missing,
    // configuration write channel
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [rwmm_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [rwmm_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import rwmm_pkg::*;

    `include "running_window_min_max_defines.svh"

    // configuration registers
    logic             select_max_reg,   select_max_next;
    logic [1:0]       window_mode_reg,  window_mode_next;
    logic [6:0]       fixed_window_reg, fixed_window_next;
    logic             skip_missing_reg, skip_missing_next;
    logic             pad_start_reg,    pad_start_next;

    // series state
    logic [LEN_W-1:0] items_seen_reg,   items_seen_next;
    logic [LEN_W-1:0] series_index_reg, series_index_next;
    logic signed [SAMPLE_WIDTH-1:0] run_ext_reg, run_ext_next;
    logic             run_valid_reg,    run_valid_next;

    // scan control
    logic             scan_reg,         scan_next;
    logic [LEN_W-1:0] scan_cnt_reg,     scan_cnt_next;
    logic             force_miss_reg,   force_miss_next;
    token_t           head_reg,         head_next;

    // output register
    logic             out_valid_reg,    out_valid_next;
    logic signed [SAMPLE_WIDTH-1:0] out_value_reg, out_value_next;
    logic             out_miss_reg,     out_miss_next;

    logic             in_fire;
    logic             out_fire;
    logic             out_free;
    logic             capture;
    logic             tok_en;
    logic             windowed;
    logic [LEN_W-1:0] idx;
    logic [LEN_W-1:0] pad_count;
    logic [LEN_W-1:0] win_len;
    logic             base_valid;
    logic             cum_valid;

    sample_t          new_sample;
    sample_t          chain_sample [WINDOW_MAX+1];
    token_t           chain_tok    [WINDOW_MAX+1];

    // ---------------------------------------------------------------------
    // Handshakes. Hold off new transfers while a scan is running or the
    // output slot cannot be freed in this cycle.
    // ---------------------------------------------------------------------
    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = scan_reg || !out_free;
    assign in_fire   = in_valid && !in_stall;
    assign out_fire  = out_valid_reg && !out_stall;
    assign cfg_ready = 1'b1;

    assign windowed  = (window_mode_reg == MODE_FIXED) || (window_mode_reg == MODE_PER_ITEM);

    // token has reached the far end of the row once the counter drains
    assign capture   = scan_reg && (scan_cnt_reg == '0) && out_free;
    assign tok_en    = scan_reg && (scan_cnt_reg != '0);

    // ---------------------------------------------------------------------
    // History row: cell 0 holds the newest sample. A transfer shifts every
    // slot one place down; the scan token then ripples through the row.
    // ---------------------------------------------------------------------
    assign new_sample.value = sample_value;
    assign new_sample.valid = !sample_missing;
    assign chain_sample[0]  = new_sample;
    assign chain_tok[0]     = head_reg;

    for (genvar k = 0; k < WINDOW_MAX; k++)
    begin : g_cell
        rwmm_cell u_cell (
            .clk        (clk),
            .shift_en   (in_fire),
            .tok_en     (tok_en),
            .select_max (select_max_reg),
            .sample_in  (chain_sample[k]),
            .sample_out (chain_sample[k+1]),
            .tok_in     (chain_tok[k]),
            .tok_out    (chain_tok[k+1])
        );
    end

    // ---------------------------------------------------------------------
    // Next-state logic
    // ---------------------------------------------------------------------
    always_comb
    begin
        select_max_next   = select_max_reg;
        window_mode_next  = window_mode_reg;
        fixed_window_next = fixed_window_reg;
        skip_missing_next = skip_missing_reg;
        pad_start_next    = pad_start_reg;

        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_SELECT_MAX:   select_max_next   = cfg_data[0];
                CFG_WINDOW_MODE:  window_mode_next  = cfg_data[1:0];
                CFG_FIXED_WINDOW: fixed_window_next = cfg_data[6:0];
                CFG_SKIP_MISSING: skip_missing_next = cfg_data[0];
                CFG_PAD_START:    pad_start_next    = cfg_data[0];
                default:          ;
            endcase
        end

        // series bookkeeping for the item on the input port
        idx = series_start ? '0 : series_index_reg;
        if (series_start)
        begin
            items_seen_next = LEN_W'(1);
        end
        else if (items_seen_reg < WIN_MAX_L)
        begin
            items_seen_next = items_seen_reg + LEN_W'(1);
        end
        else
        begin
            items_seen_next = items_seen_reg;
        end
        series_index_next = (idx < WIN_MAX_L) ? idx + LEN_W'(1) : idx;

        base_valid   = series_start ? 1'b0 : run_valid_reg;
        run_ext_next = run_ext_reg;
        if (!sample_missing &&
            (!base_valid || rwmm_better(sample_value, run_ext_reg, select_max_reg)))
        begin
            run_ext_next = sample_value;
        end
        run_valid_next = base_valid || !sample_missing;

        // window length, clipped to the samples of this series
        win_len = rwmm_clip((window_mode_reg == MODE_FIXED) ? fixed_window_reg : window_len);
        if (win_len > items_seen_next)
        begin
            win_len = items_seen_next;
        end

        // padding wins over every other outcome
        pad_count = (fixed_window_reg == '0) ? '0 : rwmm_clip(fixed_window_reg) - LEN_W'(1);
        force_miss_next = (!skip_missing_reg && sample_missing) ||
                          (pad_start_reg && (idx < pad_count));
        cum_valid = run_valid_next && !force_miss_next;

        head_next            = head_reg;
        head_next.remaining  = win_len;
        head_next.best_valid = 1'b0;

        scan_next      = scan_reg;
        scan_cnt_next  = scan_cnt_reg;
        out_valid_next = out_valid_reg;
        out_value_next = out_value_reg;
        out_miss_next  = out_miss_reg;

        if (out_fire)
        begin
            out_valid_next = 1'b0;
        end

        if (tok_en)
        begin
            scan_cnt_next = scan_cnt_reg - LEN_W'(1);
        end

        if (in_fire)
        begin
            if (windowed)
            begin
                scan_next     = 1'b1;
                scan_cnt_next = WIN_MAX_L;
            end
            else
            begin
                out_valid_next = 1'b1;
                out_value_next = cum_valid ? run_ext_next : '0;
                out_miss_next  = !cum_valid;
            end
        end

        if (capture)
        begin
            scan_next      = 1'b0;
            out_valid_next = 1'b1;
            out_miss_next  = !(chain_tok[WINDOW_MAX].best_valid && !force_miss_reg);
            out_value_next = out_miss_next ? '0 : chain_tok[WINDOW_MAX].best;
        end
    end

    // ---------------------------------------------------------------------
    // Control registers
    // ---------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            select_max_reg   <= 1'b0;
            window_mode_reg  <= MODE_CUMULATIVE;
            fixed_window_reg <= '0;
            skip_missing_reg <= 1'b1;
            pad_start_reg    <= 1'b0;
            items_seen_reg   <= '0;
            series_index_reg <= '0;
            run_ext_reg      <= '0;
            run_valid_reg    <= 1'b0;
            scan_reg         <= 1'b0;
            scan_cnt_reg     <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            select_max_reg   <= select_max_next;
            window_mode_reg  <= window_mode_next;
            fixed_window_reg <= fixed_window_next;
            skip_missing_reg <= skip_missing_next;
            pad_start_reg    <= pad_start_next;
            scan_reg         <= scan_next;
            scan_cnt_reg     <= scan_cnt_next;
            out_valid_reg    <= out_valid_next;
            if (in_fire)
            begin
                items_seen_reg   <= items_seen_next;
                series_index_reg <= series_index_next;
                run_ext_reg      <= run_ext_next;
                run_valid_reg    <= run_valid_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            head_reg       <= head_next;
            force_miss_reg <= force_miss_next;
        end
        out_value_reg <= out_value_next;
        out_miss_reg  <= out_miss_next;
    end

    assign out_valid       = out_valid_reg;
    assign extreme_value   = out_value_reg;
    assign extreme_missing = out_miss_reg;

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    `RWMM_ASSERT_NXT(a_accept_busy, in_valid && !in_stall, scan_reg || out_valid_reg)
    `RWMM_ASSERT_IMP(a_scan_blocks, scan_reg, in_stall)
    `RWMM_ASSERT_IMP(a_missing_zero, out_valid_reg && extreme_missing, extreme_value == '0)
    `RWMM_ASSERT_NXT(a_capture, capture, out_valid_reg && !scan_reg)

endmodule

@@ rtl/core/rwmm_cell.sv @@
// ---------------------------------------------------------------------------
// rwmm_cell
// One history slot plus one stage of the scan token that ripples down the row.
// ---------------------------------------------------------------------------
module rwmm_cell (
    input  logic             clk,
    input  logic             shift_en,
    input  logic             tok_en,
    input  logic             select_max,
    input  rwmm_pkg::sample_t sample_in,
    output rwmm_pkg::sample_t sample_out,
    input  rwmm_pkg::token_t  tok_in,
    output rwmm_pkg::token_t  tok_out
);
    import rwmm_pkg::*;

    sample_t sample_reg;
    token_t  tok_reg;
    token_t  tok_next;
    logic    take;

    // fold this slot into the token while the window still covers it
    always_comb
    begin
        take = (tok_in.remaining != '0) && sample_reg.valid &&
               (!tok_in.best_valid || rwmm_better(sample_reg.value, tok_in.best, select_max));
        tok_next = tok_in;
        if (take)
        begin
            tok_next.best       = sample_reg.value;
            tok_next.best_valid = 1'b1;
        end
        if (tok_in.remaining != '0)
        begin
            tok_next.remaining = tok_in.remaining - LEN_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            sample_reg <= sample_in;
        end
        if (tok_en)
        begin
            tok_reg <= tok_next;
        end
    end

    assign sample_out = sample_reg;
    assign tok_out    = tok_reg;

endmodule

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: running window min/max testbench
// Streams Q16.16 samples through the block under many register settings and
// compares every result against an in-bench model of the windowed extreme.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rwmm_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    // Window mode 3 is unused and must behave as cumulative
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    // Drain pause: one windowed scan plus margin
    localparam int DRAIN_CYCLES = WINDOW_MAX + 16;

    typedef struct {
        logic signed [SAMPLE_WIDTH-1:0] value;
        logic                           missing;
        logic [WIN_IN_W-1:0]            wlen;
        logic                           start;
    } sample_item_t;

    typedef struct {
        logic signed [SAMPLE_WIDTH-1:0] value;
        logic                           missing;
    } extreme_t;

    logic                           clk;
    logic                           rst_n;
    logic                           in_valid;
    logic                           in_stall;
    logic signed [SAMPLE_WIDTH-1:0] sample_value;
    logic                           sample_missing;
    logic [WIN_IN_W-1:0]            window_len;
    logic                           series_start;
    logic                           out_valid;
    logic                           out_stall;
    logic signed [SAMPLE_WIDTH-1:0] extreme_value;
    logic                           extreme_missing;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [CFG_IDX_W-1:0]           cfg_index;
    logic [CFG_DATA_W-1:0]          cfg_data;

    running_window_min_max i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .sample_value    (sample_value),
        .sample_missing  (sample_missing),
        .window_len      (window_len),
        .series_start    (series_start),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .extreme_value   (extreme_value),
        .extreme_missing (extreme_missing),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    // Stimulus and scoreboard storage
    sample_item_t pending_items[$];
    extreme_t     expected_extremes[$];
    int           fail_count = 0;
    int           cycle_count = 0;

    // Traffic shaping controls shared between the sequencer and the drivers
    logic quiet_phase = 1'b0;   // no idling at all in the closing phase
    logic hold_request = 1'b0;  // ask the receiver for one long hold-off
    int   hold_left = 0;
    int   send_gap = 0;
    int   recv_gap = 0;
    logic in_took = 1'b0;       // input transfer happened at the last rising edge

    // Model copy of the configuration registers (reset values)
    logic       cfg_sel_max  = 1'b0;
    logic [1:0] cfg_mode     = MODE_CUMULATIVE;
    logic [6:0] cfg_fixed    = 7'd0;
    logic       cfg_skip     = 1'b1;
    logic       cfg_pad      = 1'b0;

    // Model copy of the block state
    logic signed [SAMPLE_WIDTH-1:0] hist_value[WINDOW_MAX];
    logic                           hist_ok[WINDOW_MAX];
    int                             write_slot = 0;
    int                             series_seen = 0;
    int                             series_pos = 0;
    logic signed [SAMPLE_WIDTH-1:0] series_best = '0;
    logic                           series_best_ok = 1'b0;

    // ------------------------------------------------------------------------
    // Clock, cycle limit
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Model helpers
    // ------------------------------------------------------------------------

    // True when a strictly beats b under the current selector
    function automatic logic beats(input logic signed [SAMPLE_WIDTH-1:0] a,
                                   input logic signed [SAMPLE_WIDTH-1:0] b);
        logic res;
        if (cfg_sel_max)
        begin
            res = (a > b);
        end
        else
        begin
            res = (a < b);
        end
        return res;
    endfunction

    // Clamp a window length into 1..WINDOW_MAX
    function automatic int clamp_window(input int len);
        int res;
        if (len < 1)
        begin
            res = 1;
        end
        else if (len > WINDOW_MAX)
        begin
            res = WINDOW_MAX;
        end
        else
        begin
            res = len;
        end
        return res;
    endfunction

    // Advance the model by one accepted sample and queue the extreme it yields
    task automatic predict_extreme(input sample_item_t it);
        int       cur;
        int       span;
        int       slot;
        int       pos;
        int       pad_count;
        logic     ok;
        extreme_t res;
        logic signed [SAMPLE_WIDTH-1:0] best;
        ok   = 1'b0;
        best = '0;

        // Series start clears the window and the cumulative extreme
        if (it.start)
        begin
            series_seen    = 0;
            series_pos     = 0;
            series_best_ok = 1'b0;
        end

        cur = write_slot;
        hist_value[cur] = it.value;
        hist_ok[cur]    = !it.missing;
        write_slot      = (cur + 1) % WINDOW_MAX;
        if (series_seen < WINDOW_MAX)
        begin
            series_seen++;
        end

        if (!it.missing && (!series_best_ok || beats(it.value, series_best)))
        begin
            series_best    = it.value;
            series_best_ok = 1'b1;
        end

        pos = series_pos;
        if (series_pos < WINDOW_MAX)
        begin
            series_pos++;
        end

        // Unskipped missing sample forces a missing result
        if (cfg_skip || !it.missing)
        begin
            if (cfg_mode == MODE_FIXED || cfg_mode == MODE_PER_ITEM)
            begin
                span = clamp_window(cfg_mode == MODE_FIXED ? int'(cfg_fixed) : int'(it.wlen));
                if (span > series_seen)
                begin
                    span = series_seen;
                end
                for (int j = 0; j < span; j++)
                begin
                    slot = (cur + WINDOW_MAX - j) % WINDOW_MAX;
                    if (hist_ok[slot] && (!ok || beats(hist_value[slot], best)))
                    begin
                        best = hist_value[slot];
                        ok   = 1'b1;
                    end
                end
            end
            else
            begin
                // Cumulative, and the unused mode falls back to it
                ok   = series_best_ok;
                best = series_best;
            end
        end

        // Padding wins over everything else
        pad_count = (cfg_fixed == 7'd0) ? 0 : clamp_window(int'(cfg_fixed)) - 1;
        if (cfg_pad && pos < pad_count)
        begin
            ok = 1'b0;
        end

        res.value   = ok ? best : '0;
        res.missing = !ok;
        expected_extremes.push_back(res);
    endtask

    task automatic report_mismatch(input string what);
        fail_count++;
        $display("MISMATCH at cycle %0d: %s", cycle_count, what);
    endtask

    // ------------------------------------------------------------------------
    // Input driver: present queued samples, hold them while stalled
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin : drive_samples
        logic         nv;
        sample_item_t nx;
        nv = in_valid;
        nx.value   = sample_value;
        nx.missing = sample_missing;
        nx.wlen    = window_len;
        nx.start   = series_start;
        if (in_valid && in_took)
        begin
            nv = 1'b0;
        end
        if (!nv && rst_n)
        begin
            if (send_gap > 0)
            begin
                send_gap--;
            end
            else if (pending_items.size() != 0)
            begin
                nx = pending_items.pop_front();
                nv = 1'b1;
                // Keep offering during the long hold so the block backs up
                if (!quiet_phase && hold_left == 0 && $urandom_range(0, 7) == 0)
                begin
                    send_gap = $urandom_range(1, 18);
                end
            end
        end
        in_valid       <= nv;
        sample_value   <= nx.value;
        sample_missing <= nx.missing;
        window_len     <= nx.wlen;
        series_start   <= nx.start;
    end

    // ------------------------------------------------------------------------
    // Output receiver: random stall bursts plus one long hold-off on request
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin : drive_stall
        logic ns;
        if (hold_request)
        begin
            hold_left    = 300;
            hold_request = 1'b0;
        end
        if (hold_left > 0)
        begin
            ns = 1'b1;
            hold_left--;
        end
        else if (recv_gap > 0)
        begin
            ns = 1'b1;
            recv_gap--;
        end
        else
        begin
            ns = 1'b0;
            if (!quiet_phase && $urandom_range(0, 9) == 0)
            begin
                recv_gap = $urandom_range(1, 18);
            end
        end
        out_stall <= ns;
    end

    // ------------------------------------------------------------------------
    // Monitor: predict on every input transfer, check every output transfer
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : watch_ports
        sample_item_t it;
        extreme_t     exp_res;
        in_took = rst_n && in_valid && !in_stall;
        if (in_took)
        begin
            it.value   = sample_value;
            it.missing = sample_missing;
            it.wlen    = window_len;
            it.start   = series_start;
            predict_extreme(it);
        end
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_extremes.size() == 0)
            begin
                report_mismatch("result transfer with nothing expected");
            end
            else
            begin
                exp_res = expected_extremes.pop_front();
                if (extreme_value !== exp_res.value)
                begin
                    report_mismatch($sformatf("extreme_value got %h want %h",
                                              extreme_value, exp_res.value));
                end
                if (extreme_missing !== exp_res.missing)
                begin
                    report_mismatch($sformatf("extreme_missing got %b want %b",
                                              extreme_missing, exp_res.missing));
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sequencer helpers
    // ------------------------------------------------------------------------

    // Write one register through the config channel; mirror it in the model
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        case (idx)
            CFG_SELECT_MAX:   cfg_sel_max = data[0];
            CFG_WINDOW_MODE:  cfg_mode    = data[1:0];
            CFG_FIXED_WINDOW: cfg_fixed   = data[6:0];
            CFG_SKIP_MISSING: cfg_skip    = data[0];
            CFG_PAD_START:    cfg_pad     = data[0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic configure(input logic sel, input logic [1:0] mode, input logic [6:0] fixed,
                             input logic skip, input logic pad);
        write_register(CFG_SELECT_MAX, CFG_DATA_W'(sel));
        write_register(CFG_WINDOW_MODE, CFG_DATA_W'(mode));
        write_register(CFG_FIXED_WINDOW, CFG_DATA_W'(fixed));
        write_register(CFG_SKIP_MISSING, CFG_DATA_W'(skip));
        write_register(CFG_PAD_START, CFG_DATA_W'(pad));
    endtask

    function automatic void queue_sample(input logic signed [SAMPLE_WIDTH-1:0] value,
                                         input logic missing, input logic [6:0] wlen,
                                         input logic start);
        sample_item_t it;
        it.value   = value;
        it.missing = missing;
        it.wlen    = wlen;
        it.start   = start;
        pending_items.push_back(it);
    endfunction

    // Random series: mostly long well-formed runs, with dense extremes and ties
    task automatic queue_random_samples(input int count);
        int                             miss_pct;
        int                             start_odds;
        logic signed [SAMPLE_WIDTH-1:0] v;
        logic [6:0]                     wl;
        miss_pct   = $urandom_range(0, 60);
        start_odds = $urandom_range(8, 40);
        for (int n = 0; n < count; n++)
        begin
            case ($urandom_range(0, 9))
                0:       v = 32'sh7fffffff;
                1:       v = 32'sh80000000;
                2, 3, 4: v = $signed($urandom_range(0, 20)) - 32'sd10;
                default: v = $urandom;
            endcase
            case ($urandom_range(0, 7))
                0:       wl = 7'd0;
                1:       wl = 7'd64;
                2:       wl = 7'($urandom_range(65, 127));
                3:       wl = 7'($urandom_range(0, 127));
                default: wl = 7'($urandom_range(1, 12));
            endcase
            queue_sample(v, $urandom_range(0, 99) < miss_pct, wl,
                         $urandom_range(0, start_odds) == 0);
        end
    endtask

    // Wait until every sample went in and every result came out, then settle
    task automatic drain;
        while (pending_items.size() != 0 || in_valid || expected_extremes.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin : run_test
        logic [6:0] fw;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        sample_value   = '0;
        sample_missing = 1'b0;
        window_len     = '0;
        series_start   = 1'b0;
        out_stall      = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        for (int i = 0; i < WINDOW_MAX; i++)
        begin
            hist_value[i] = '0;
            hist_ok[i]    = 1'b0;
        end
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset defaults: cumulative minimum; first sample has no series mark
        queue_sample(32'sd0, 1'b0, 7'd0, 1'b0);
        queue_sample(32'sh7fffffff, 1'b0, 7'd64, 1'b0);
        queue_sample(32'sh80000000, 1'b0, 7'd127, 1'b0);
        queue_sample(32'sh80000000, 1'b1, 7'd1, 1'b0);
        queue_sample(-32'sd1, 1'b0, 7'd5, 1'b1);
        queue_sample(32'sh7fffffff, 1'b1, 7'd0, 1'b0);
        queue_sample(32'sd1, 1'b0, 7'd3, 1'b0);
        drain();

        // Flip the selector mid-series: cumulative keeps its value, then tracks max
        configure(1'b1, MODE_CUMULATIVE, 7'd0, 1'b1, 1'b0);
        queue_sample(-32'sd2, 1'b0, 7'd2, 1'b0);
        queue_sample(32'sd65536, 1'b0, 7'd2, 1'b0);
        drain();

        // Fixed window of three, padding on, unskipped missing samples
        configure(1'b1, MODE_FIXED, 7'd3, 1'b0, 1'b1);
        queue_sample(32'sd10, 1'b0, 7'd0, 1'b1);
        queue_sample(32'sd20, 1'b0, 7'd0, 1'b0);
        queue_sample(32'sd5, 1'b1, 7'd0, 1'b0);
        queue_sample(32'sd7, 1'b0, 7'd0, 1'b0);
        queue_sample(32'sd3, 1'b0, 7'd0, 1'b0);
        drain();

        // Per-item windows; padding is on but a zero fixed window pads nothing; an all-missing window; unused mode
        configure(1'b0, MODE_PER_ITEM, 7'd0, 1'b1, 1'b1);
        queue_sample(32'sd4, 1'b1, 7'd1, 1'b1);
        queue_sample(32'sd8, 1'b1, 7'd64, 1'b0);
        queue_sample(32'sd9, 1'b0, 7'd0, 1'b0);
        queue_sample(-32'sd9, 1'b0, 7'd127, 1'b0);
        queue_sample(32'sd1, 1'b0, 7'd1, 1'b0);
        drain();
        configure(1'b0, MODE_UNUSED, 7'd64, 1'b0, 1'b0);
        queue_sample(32'sd6, 1'b0, 7'd1, 1'b1);
        queue_sample(32'sd2, 1'b1, 7'd1, 1'b0);
        queue_sample(32'sd12, 1'b0, 7'd1, 1'b0);
        drain();

        // Random phases; each one reprograms every register
        for (int ph = 0; ph < 10; ph++)
        begin
            case ($urandom_range(0, 5))
                0:       fw = 7'd0;
                1:       fw = 7'd1;
                2:       fw = 7'd64;
                3:       fw = 7'($urandom_range(0, 64));
                default: fw = 7'($urandom_range(2, 10));
            endcase
            case (ph)
                0:       configure(1'($urandom_range(0, 1)), MODE_CUMULATIVE, fw,
                                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                1:       configure(1'($urandom_range(0, 1)), MODE_FIXED, 7'd64,
                                   1'($urandom_range(0, 1)), 1'b1);
                2:       configure(1'($urandom_range(0, 1)), MODE_PER_ITEM, 7'd0,
                                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                default: configure(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)), fw,
                                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            endcase
            // Closing phase runs without any idling
            if (ph == 9)
            begin
                quiet_phase = 1'b1;
            end
            // Hold the receiver off while the cumulative pipe fills and backs up
            if (ph == 0)
            begin
                hold_request = 1'b1;
            end
            queue_random_samples(40);
            drain();
        end

        if (fail_count == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/rwmm_pkg.sv
rtl/core/rwmm_cell.sv
rtl/core/running_window_min_max.sv
verif/tb_top.sv
